@@ sv/mlnp_pkg.sv @@
// shared types and constants for the last-note-priority midi voice
package mlnp_pkg;

    // default stack geometry
    localparam int STACK_SLOTS_DEF = 15;
    localparam int COUNT_CAP_DEF   = 14;

    // request queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    // midi status decoding
    localparam logic [7:0] STATUS_CMD_MASK = 8'hF0;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_CTRL     = 8'hB0;
    localparam logic [7:0] STATUS_BEND     = 8'hE0;

    localparam logic       MODE_PANIC  = 1'b1;
    localparam logic [13:0] BEND_CENTRE = 14'd8192;

    // classified command carried through the queue
    typedef enum logic [2:0] {
        CMD_OTHER    = 3'd0,
        CMD_PANIC    = 3'd1,
        CMD_NOTE_ON  = 3'd2,
        CMD_NOTE_OFF = 3'd3,
        CMD_BEND     = 3'd4,
        CMD_CTRL     = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [6:0] data1;
        logic [6:0] data2;
    } t_req;

    // handshake of one request stage
    typedef struct packed {
        logic valid;
        t_req req;
    } t_req_chan;

endpackage

@@ sv/mlnp_front.sv @@
// front end: accepts midi items and classifies them into commands
module mlnp_front (
    input  logic              i_in_valid,
    input  logic              i_mode,
    input  logic [7:0]        i_status,
    input  logic [6:0]        i_data1,
    input  logic [6:0]        i_data2,
    input  logic              i_push_ready,
    output logic              o_in_ready,
    output mlnp_pkg::t_req_chan o_push
);

    logic [7:0] cmd_bits;

    // command nibble decode, panic overrides the status byte
    always_comb begin
        cmd_bits = i_status & mlnp_pkg::STATUS_CMD_MASK;
        o_push.valid      = i_in_valid;
        o_push.req.data1  = i_data1;
        o_push.req.data2  = i_data2;
        if (i_mode == mlnp_pkg::MODE_PANIC) begin
            o_push.req.cmd = mlnp_pkg::CMD_PANIC;
        end else begin
            unique case (cmd_bits)
                mlnp_pkg::STATUS_NOTE_ON:  o_push.req.cmd = mlnp_pkg::CMD_NOTE_ON;
                mlnp_pkg::STATUS_NOTE_OFF: o_push.req.cmd = mlnp_pkg::CMD_NOTE_OFF;
                mlnp_pkg::STATUS_BEND:     o_push.req.cmd = mlnp_pkg::CMD_BEND;
                mlnp_pkg::STATUS_CTRL:     o_push.req.cmd = mlnp_pkg::CMD_CTRL;
                default:                   o_push.req.cmd = mlnp_pkg::CMD_OTHER;
            endcase
        end
    end

    // the front takes a request whenever the queue has room
    assign o_in_ready = i_push_ready;

endmodule

@@ sv/mlnp_queue.sv @@
// short request queue decoupling the front end from the stack engine
module mlnp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlnp_pkg::t_req_chan i_push,
    output logic                o_push_ready,
    output mlnp_pkg::t_req_chan o_pop,
    input  logic                i_pop_ready
);

    localparam int AW = mlnp_pkg::QUEUE_AW;
    localparam int DEPTH = mlnp_pkg::QUEUE_DEPTH;

    mlnp_pkg::t_req   r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_fill;
    logic             push_fire;
    logic             pop_fire;

    assign o_push_ready = (r_fill != (AW+1)'(DEPTH));
    assign o_pop.valid  = (r_fill != '0);
    assign o_pop.req    = r_mem[r_rd_ptr];
    assign push_fire    = i_push.valid & o_push_ready;
    assign pop_fire     = o_pop.valid & i_pop_ready;

    // storage write
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_push.req;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (push_fire && !pop_fire) begin
                r_fill <= r_fill + (AW+1)'(1);
            end else if (pop_fire && !push_fire) begin
                r_fill <= r_fill - (AW+1)'(1);
            end
        end
    end

endmodule

@@ sv/mlnp_back.sv @@
// back end: held-note stack, voice state and the result register
module mlnp_back #(
    parameter int STACK_SLOTS = mlnp_pkg::STACK_SLOTS_DEF,
    parameter int COUNT_CAP   = mlnp_pkg::COUNT_CAP_DEF,
    localparam int CW = $clog2(COUNT_CAP + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlnp_pkg::t_req_chan i_pop,
    output logic                o_pop_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [6:0]          o_current_note,
    output logic [6:0]          o_current_velocity,
    output logic                o_gate_on_event,
    output logic                o_gate_off_event,
    output logic                o_pitch_changed,
    output logic [13:0]         o_bend_value,
    output logic [6:0]          o_mod_value,
    output logic [CW-1:0]       o_held_count
);

    localparam int SW   = $clog2(STACK_SLOTS + 1);
    localparam int CMPW = ((SW > CW) ? SW : CW) + 1;

    logic [6:0]    r_slot [STACK_SLOTS];
    logic [6:0]    n_slot [STACK_SLOTS];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [6:0]    r_note;
    logic [6:0]    n_note;
    logic [6:0]    r_vel;
    logic [6:0]    n_vel;
    logic [13:0]   r_bend;
    logic [13:0]   n_bend;
    logic [6:0]    r_mod;
    logic [6:0]    n_mod;
    logic          n_gate_on;
    logic          n_gate_off;
    logic          n_pitch;

    logic             r_out_valid;
    logic [6:0]       r_out_note;
    logic [6:0]       r_out_vel;
    logic             r_out_gate_on;
    logic             r_out_gate_off;
    logic             r_out_pitch;
    logic [13:0]      r_out_bend;
    logic [6:0]       r_out_mod;
    logic [CW-1:0]    r_out_count;

    logic             step;
    logic [CMPW-1:0]  count_x;
    logic [CMPW-1:0]  top_x;
    logic             found;
    logic [6:0]       top_note;

    // one request per cycle while the result register is free or draining
    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign step        = i_pop.valid && o_pop_ready;
    assign count_x     = CMPW'(r_count);

    // next voice state for the request at the head of the queue
    always_comb begin
        for (int i = 0; i < STACK_SLOTS; i++) begin
            n_slot[i] = r_slot[i];
        end
        n_count    = r_count;
        n_note     = r_note;
        n_vel      = r_vel;
        n_bend     = r_bend;
        n_mod      = r_mod;
        n_gate_on  = 1'b0;
        n_gate_off = 1'b0;
        n_pitch    = 1'b0;
        found      = 1'b0;
        top_x      = '0;
        top_note   = '0;
        unique case (i_pop.req.cmd)
            mlnp_pkg::CMD_PANIC: begin
                n_count    = '0;
                n_gate_off = 1'b1;
            end
            mlnp_pkg::CMD_NOTE_ON: begin
                n_note    = i_pop.req.data1;
                n_vel     = i_pop.req.data2;
                n_pitch   = 1'b1;
                n_gate_on = 1'b1;
                // write the slot at the count, dropped beyond the stack
                for (int i = 0; i < STACK_SLOTS; i++) begin
                    if (count_x == CMPW'(i)) begin
                        n_slot[i] = i_pop.req.data1;
                    end
                end
                if (r_count < CW'(COUNT_CAP)) begin
                    n_count = r_count + CW'(1);
                end
            end
            mlnp_pkg::CMD_NOTE_OFF: begin
                // close the gap from the first match upward
                for (int i = 0; i < STACK_SLOTS; i++) begin
                    if (CMPW'(i) < count_x) begin
                        found = found || (r_slot[i] == i_pop.req.data1);
                        if (found) begin
                            n_slot[i] = (i + 1 < STACK_SLOTS) ? r_slot[(i + 1) % STACK_SLOTS]
                                                              : 7'd0;
                        end
                    end
                end
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
                if (n_count == '0) begin
                    n_gate_off = 1'b1;
                end else begin
                    // fall back to the newest note still held
                    top_x = CMPW'(n_count) - CMPW'(1);
                    for (int i = 0; i < STACK_SLOTS; i++) begin
                        if (top_x == CMPW'(i)) begin
                            top_note = n_slot[i];
                        end
                    end
                    n_note  = top_note;
                    n_pitch = 1'b1;
                end
            end
            mlnp_pkg::CMD_BEND: begin
                n_bend = {i_pop.req.data2, i_pop.req.data1};
            end
            mlnp_pkg::CMD_CTRL: begin
                n_mod = i_pop.req.data2;
            end
            default: begin
            end
        endcase
    end

    // voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STACK_SLOTS; i++) begin
                r_slot[i] <= '0;
            end
            r_count <= '0;
            r_note  <= '0;
            r_vel   <= '0;
            r_bend  <= mlnp_pkg::BEND_CENTRE;
            r_mod   <= '0;
        end else if (step) begin
            for (int i = 0; i < STACK_SLOTS; i++) begin
                r_slot[i] <= n_slot[i];
            end
            r_count <= n_count;
            r_note  <= n_note;
            r_vel   <= n_vel;
            r_bend  <= n_bend;
            r_mod   <= n_mod;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop_ready) begin
            r_out_valid <= i_pop.valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_note     <= n_note;
            r_out_vel      <= n_vel;
            r_out_gate_on  <= n_gate_on;
            r_out_gate_off <= n_gate_off;
            r_out_pitch    <= n_pitch;
            r_out_bend     <= n_bend;
            r_out_mod      <= n_mod;
            r_out_count    <= n_count;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_current_note     = r_out_note;
    assign o_current_velocity = r_out_vel;
    assign o_gate_on_event    = r_out_gate_on;
    assign o_gate_off_event   = r_out_gate_off;
    assign o_pitch_changed    = r_out_pitch;
    assign o_bend_value       = r_out_bend;
    assign o_mod_value        = r_out_mod;
    assign o_held_count       = r_out_count;

endmodule

@@ sv/midi_last_note_priority_voice.sv @@
// top level of the last-note-priority monophonic midi voice
//
//   channel   direction  handshake                   payload
//   request   in         i_in_valid / o_in_ready     i_mode i_status i_data1 i_data2
//   result    out        o_out_valid / i_out_ready   o_current_note .. o_held_count
//
// one result per request; a request can be taken every cycle while the queue has
// room (the queue entry is written at the accepting edge, then the stack engine's
// compare-and-shift registers the result in the result register and sets the rate).
// a two-entry queue lets the front keep accepting while the result side stalls.
// synchronous active-low reset clears the stack, count and voice state;
// bend resets to centre.
module midi_last_note_priority_voice #(
    parameter int STACK_SLOTS = mlnp_pkg::STACK_SLOTS_DEF,
    parameter int COUNT_CAP   = mlnp_pkg::COUNT_CAP_DEF,
    localparam int CW = $clog2(COUNT_CAP + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_mode,
    input  logic [7:0]    i_status,
    input  logic [6:0]    i_data1,
    input  logic [6:0]    i_data2,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [6:0]    o_current_note,
    output logic [6:0]    o_current_velocity,
    output logic          o_gate_on_event,
    output logic          o_gate_off_event,
    output logic          o_pitch_changed,
    output logic [13:0]   o_bend_value,
    output logic [6:0]    o_mod_value,
    output logic [CW-1:0] o_held_count
);

    mlnp_pkg::t_req_chan push;
    mlnp_pkg::t_req_chan pop;
    logic                push_ready;
    logic                pop_ready;

    // classify incoming requests
    mlnp_front u_front (
        .i_in_valid   (i_in_valid),
        .i_mode       (i_mode),
        .i_status     (i_status),
        .i_data1      (i_data1),
        .i_data2      (i_data2),
        .i_push_ready (push_ready),
        .o_in_ready   (o_in_ready),
        .o_push       (push)
    );

    // decoupling queue
    mlnp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop        (pop),
        .i_pop_ready  (pop_ready)
    );

    // stack engine and result register
    mlnp_back #(
        .STACK_SLOTS (STACK_SLOTS),
        .COUNT_CAP   (COUNT_CAP)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_pop              (pop),
        .o_pop_ready        (pop_ready),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_current_note     (o_current_note),
        .o_current_velocity (o_current_velocity),
        .o_gate_on_event    (o_gate_on_event),
        .o_gate_off_event   (o_gate_off_event),
        .o_pitch_changed    (o_pitch_changed),
        .o_bend_value       (o_bend_value),
        .o_mod_value        (o_mod_value),
        .o_held_count       (o_held_count)
    );

endmodule

@@ sv/mlnp_checker.sv @@
// port-level checks for the midi voice, bound to the top level
module mlnp_checker #(
    parameter int COUNT_CAP = mlnp_pkg::COUNT_CAP_DEF,
    localparam int CW = $clog2(COUNT_CAP + 1)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input logic [6:0]    o_current_note,
    input logic          o_gate_on_event,
    input logic          o_gate_off_event,
    input logic          o_pitch_changed,
    input logic [CW-1:0] o_held_count
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_current_note)
            && $stable(o_held_count))
        else $error("result changed while stalled");

    // a request never both triggers and releases
    a_gate_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_gate_on_event && o_gate_off_event))
        else $error("gate on and off in one result");

    // a retrigger always sets pitch and leaves a note held
    a_gate_on_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_gate_on_event |-> o_pitch_changed && (o_held_count != '0))
        else $error("gate on without a held note");

    // a release leaves the stack empty and no pitch change
    a_gate_off_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_gate_off_event |-> (o_held_count == '0) && !o_pitch_changed)
        else $error("gate off with notes held");

    // the held count never passes the cap
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_held_count <= CW'(COUNT_CAP)))
        else $error("held count above cap");

endmodule

bind midi_last_note_priority_voice mlnp_checker #(
    .COUNT_CAP (COUNT_CAP)
) u_mlnp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_current_note   (o_current_note),
    .o_gate_on_event  (o_gate_on_event),
    .o_gate_off_event (o_gate_off_event),
    .o_pitch_changed  (o_pitch_changed),
    .o_held_count     (o_held_count)
);

@@ test/midi_voice_report_checker.sv @@
// checker for the midi voice: predicts every voice report and compares it with the block
module midi_voice_report_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_status,
    input  logic [6:0]  i_data1,
    input  logic [6:0]  i_data2,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [6:0]  i_current_note,
    input  logic [6:0]  i_current_velocity,
    input  logic        i_gate_on_event,
    input  logic        i_gate_off_event,
    input  logic        i_pitch_changed,
    input  logic [13:0] i_bend_value,
    input  logic [6:0]  i_mod_value,
    input  logic [3:0]  i_held_count,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic        gate_on;
        logic        gate_off;
        logic        pitch;
        logic [13:0] bend;
        logic [6:0]  modv;
        logic [3:0]  held;
    } t_voice_report;

    // predicted voice state
    logic [6:0]    held_slots [mlnp_pkg::STACK_SLOTS_DEF];
    int            held_total;
    logic [6:0]    sounding;
    logic [6:0]    velocity_reg;
    logic [13:0]   bend_reg;
    logic [6:0]    mod_reg;

    t_voice_report reports_due [$];
    int            mismatches;
    int            reports_seen;

    // applies one request to the predicted state and returns the report it yields
    function automatic t_voice_report apply_request(input logic mode, input logic [7:0] status,
            input logic [6:0] note, input logic [6:0] value);
        mlnp_pkg::t_cmd cmd;
        t_voice_report  rep;
        bit             shifting;
        rep      = '0;
        shifting = 1'b0;
        if (mode == mlnp_pkg::MODE_PANIC) begin
            cmd = mlnp_pkg::CMD_PANIC;
        end else begin
            case (status & mlnp_pkg::STATUS_CMD_MASK)
                mlnp_pkg::STATUS_NOTE_ON:  cmd = mlnp_pkg::CMD_NOTE_ON;
                mlnp_pkg::STATUS_NOTE_OFF: cmd = mlnp_pkg::CMD_NOTE_OFF;
                mlnp_pkg::STATUS_BEND:     cmd = mlnp_pkg::CMD_BEND;
                mlnp_pkg::STATUS_CTRL:     cmd = mlnp_pkg::CMD_CTRL;
                default:                   cmd = mlnp_pkg::CMD_OTHER;
            endcase
        end
        case (cmd)
            mlnp_pkg::CMD_PANIC: begin
                // slot contents stay, only the count goes
                held_total   = 0;
                rep.gate_off = 1'b1;
            end
            mlnp_pkg::CMD_NOTE_ON: begin
                sounding     = note;
                velocity_reg = value;
                rep.pitch    = 1'b1;
                rep.gate_on  = 1'b1;
                if (held_total < mlnp_pkg::STACK_SLOTS_DEF) begin
                    held_slots[held_total] = note;
                end
                if (held_total < mlnp_pkg::COUNT_CAP_DEF) begin
                    held_total++;
                end
            end
            mlnp_pkg::CMD_NOTE_OFF: begin
                // close the gap left by the first match
                for (int i = 0; i < held_total; i++) begin
                    if (shifting || held_slots[i] == note) begin
                        shifting      = 1'b1;
                        held_slots[i] = (i + 1 < mlnp_pkg::STACK_SLOTS_DEF)
                                        ? held_slots[i + 1] : 7'd0;
                    end
                end
                // count drops even when nothing matched
                if (held_total > 0) begin
                    held_total--;
                end
                if (held_total == 0) begin
                    rep.gate_off = 1'b1;
                end else begin
                    sounding  = held_slots[held_total - 1];
                    rep.pitch = 1'b1;
                end
            end
            mlnp_pkg::CMD_BEND: begin
                bend_reg = {value, note};
            end
            mlnp_pkg::CMD_CTRL: begin
                mod_reg = value;
            end
            default: begin
            end
        endcase
        rep.note     = sounding;
        rep.velocity = velocity_reg;
        rep.bend     = bend_reg;
        rep.modv     = mod_reg;
        rep.held     = held_total[3:0];
        return rep;
    endfunction

    function automatic string describe(input t_voice_report r);
        return $sformatf("note=%0d vel=%0d on=%0b off=%0b pitch=%0b bend=%0d mod=%0d held=%0d",
                         r.note, r.velocity, r.gate_on, r.gate_off, r.pitch, r.bend, r.modv,
                         r.held);
    endfunction

    // watch both channels
    always @(posedge i_clk) begin
        t_voice_report seen;
        t_voice_report want;
        if (!i_rst_n) begin
            foreach (held_slots[i]) held_slots[i] = '0;
            held_total   = 0;
            sounding     = '0;
            velocity_reg = '0;
            bend_reg     = mlnp_pkg::BEND_CENTRE;
            mod_reg      = '0;
            reports_due.delete();
            mismatches   = 0;
            reports_seen = 0;
        end else begin
            // compare a delivered report with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                seen = '{note: i_current_note, velocity: i_current_velocity,
                         gate_on: i_gate_on_event, gate_off: i_gate_off_event,
                         pitch: i_pitch_changed, bend: i_bend_value, modv: i_mod_value,
                         held: i_held_count};
                if (reports_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("report %0d arrived with no request pending: %s",
                                 reports_seen, describe(seen));
                    end
                end else begin
                    want = reports_due.pop_front();
                    if (seen != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("report %0d mismatch\n  expected %s\n  actual   %s",
                                     reports_seen, describe(want), describe(seen));
                        end
                    end
                end
                reports_seen++;
            end
            // predict the report of an accepted request
            if (i_in_valid && i_in_ready) begin
                reports_due.push_back(apply_request(i_mode, i_status, i_data1, i_data2));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= reports_due.size();
    end

endmodule

@@ test/midi_last_note_priority_voice_test.sv @@
// top of the midi voice test: clock, reset, request stimulus, result stalls and verdict
module midi_last_note_priority_voice_test;

    localparam logic MODE_MIDI   = ~mlnp_pkg::MODE_PANIC;
    localparam int   REQUESTS    = 750;
    // sender steady window, in requests
    localparam int   STEADY_FROM = 300;
    localparam int   STEADY_TO   = 420;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_mode     = 1'b0;
    logic [7:0]  in_status   = '0;
    logic [6:0]  in_data1    = '0;
    logic [6:0]  in_data2    = '0;
    logic        out_ready   = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [6:0]  current_note;
    logic [6:0]  current_velocity;
    logic        gate_on_event;
    logic        gate_off_event;
    logic        pitch_changed;
    logic [13:0] bend_value;
    logic [6:0]  mod_value;
    logic [3:0]  held_count;
    int          fail_count;
    int          pending;
    int          requests_sent = 0;
    int          rx_cycle      = 0;

    always #5 i_clk = ~i_clk;

    midi_last_note_priority_voice uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_mode             (in_mode),
        .i_status           (in_status),
        .i_data1            (in_data1),
        .i_data2            (in_data2),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_current_note     (current_note),
        .o_current_velocity (current_velocity),
        .o_gate_on_event    (gate_on_event),
        .o_gate_off_event   (gate_off_event),
        .o_pitch_changed    (pitch_changed),
        .o_bend_value       (bend_value),
        .o_mod_value        (mod_value),
        .o_held_count       (held_count)
    );

    midi_voice_report_checker voice_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_mode             (in_mode),
        .i_status           (in_status),
        .i_data1            (in_data1),
        .i_data2            (in_data2),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_current_note     (current_note),
        .i_current_velocity (current_velocity),
        .i_gate_on_event    (gate_on_event),
        .i_gate_off_event   (gate_off_event),
        .i_pitch_changed    (pitch_changed),
        .i_bend_value       (bend_value),
        .i_mod_value        (mod_value),
        .i_held_count       (held_count),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // result side: random stalls, one long hold-off and one stall-free stretch
    initial begin
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle >= 250 && rx_cycle < 330) begin
                out_ready <= 1'b0;
            end else if (rx_cycle >= 700 && rx_cycle < 900) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 26);
            end
        end
    end

    // offers one request and waits until it is taken
    task automatic send_request(input logic mode, input logic [7:0] status,
            input logic [6:0] data1, input logic [6:0] data2);
        if (!(requests_sent >= STEADY_FROM && requests_sent < STEADY_TO)) begin
            while ($urandom_range(99) < 26) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid  <= 1'b1;
        in_mode   <= mode;
        in_status <= status;
        in_data1  <= data1;
        in_data2  <= data2;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    // command nibble on a random midi channel
    function automatic logic [7:0] on_channel(input logic [7:0] cmd);
        return cmd | 8'($urandom_range(15));
    endfunction

    // mostly a narrow range so that note-offs find their notes and duplicates occur
    function automatic logic [6:0] pick_note();
        if ($urandom_range(3) == 0) return 7'($urandom_range(127));
        return 7'(60 + $urandom_range(7));
    endfunction

    function automatic logic [6:0] any7();
        return 7'($urandom_range(127));
    endfunction

    initial begin
        logic [6:0] phrase_notes [$];
        logic [6:0] note;
        int         pick;
        int         idx;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: note-off on an empty stack
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_OFF), 7'd60, 7'd0);
        // bend and controller extremes
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_BEND), 7'd0, 7'd0);
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_BEND), 7'd127, 7'd127);
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_CTRL), 7'd1, 7'd127);
        // commands that change nothing
        send_request(MODE_MIDI, 8'h00, 7'd127, 7'd127);
        send_request(MODE_MIDI, 8'hFF, 7'd0, 7'd0);
        // note extremes, velocity zero, a duplicate note
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_ON), 7'd127, 7'd0);
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_ON), 7'd0, 7'd127);
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_ON), 7'd0, 7'd64);
        // first match only, then a note-off with no match, then the stack empties
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_OFF), 7'd0, 7'd0);
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_OFF), 7'd99, 7'd127);
        send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_OFF), 7'd127, 7'd0);
        // run past the count cap so a note lands in the slot beyond the count
        for (int i = 0; i < 15; i++) begin
            send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_ON), 7'(40 + i),
                         any7());
        end
        // panic ignores status and data bytes
        send_request(mlnp_pkg::MODE_PANIC, mlnp_pkg::STATUS_NOTE_ON | 8'h0F, 7'd127, 7'd127);

        // random phrases, mostly chords pressed and released in any order
        while (requests_sent < REQUESTS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                repeat ($urandom_range(1, 16)) begin
                    note = pick_note();
                    phrase_notes.push_back(note);
                    send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_ON), note, any7());
                end
                while (phrase_notes.size() > 0 && $urandom_range(9) != 0) begin
                    idx = $urandom_range(phrase_notes.size() - 1);
                    send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_OFF),
                                 phrase_notes[idx], any7());
                    phrase_notes.delete(idx);
                end
            end else if (pick < 65) begin
                send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_NOTE_OFF), pick_note(),
                             any7());
            end else if (pick < 77) begin
                send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_BEND), any7(), any7());
            end else if (pick < 85) begin
                send_request(MODE_MIDI, on_channel(mlnp_pkg::STATUS_CTRL), any7(), any7());
            end else if (pick < 95) begin
                send_request(MODE_MIDI, 8'($urandom_range(255)), any7(), any7());
            end else begin
                send_request(mlnp_pkg::MODE_PANIC, 8'($urandom_range(255)), any7(), any7());
                phrase_notes.delete();
            end
        end
        in_valid <= 1'b0;

        // drain the remaining reports, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
